/* sv/mbl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbl_pkg
// Shared types, token kinds and character codes for the markup byte lexer.
// ----------------------------------------------------------------------------
package mbl_pkg;

   localparam int POS_WIDTH = 16;

   typedef logic [POS_WIDTH-1:0] pos_type;

   localparam pos_type POS_MAX = '1;
   localparam pos_type POS_ONE = pos_type'(1);

   // Token kinds carried in the kind field of a result.
   localparam logic [2:0] KIND_LBRACE    = 3'd0;
   localparam logic [2:0] KIND_RBRACE    = 3'd1;
   localparam logic [2:0] KIND_COLON     = 3'd2;
   localparam logic [2:0] KIND_SEMICOLON = 3'd3;
   localparam logic [2:0] KIND_STRING    = 3'd4;
   localparam logic [2:0] KIND_IDENT     = 3'd5;
   localparam logic [2:0] KIND_NUMBER    = 3'd6;
   localparam logic [2:0] KIND_END       = 3'd7;

   // Character codes.
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_SEMICOLON = 8'h3B;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_DASH      = 8'h2D;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;

   typedef enum logic [2:0] {
      MODE_NORMAL   = 3'd0,
      MODE_SLASH    = 3'd1,
      MODE_LINECOM  = 3'd2,
      MODE_BLOCKCOM = 3'd3,
      MODE_STRING   = 3'd4,
      MODE_ESCAPE   = 3'd5,
      MODE_IDENT    = 3'd6,
      MODE_NUMBER   = 3'd7
   } lex_mode_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       has_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       begins;
      logic       has_char;
      logic [7:0] char_value;
      pos_type    start_line;
      pos_type    start_column;
      logic       unterminated;
      logic       last;
   } rsp_type;

endpackage

/* sv/markup_byte_lexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markup_byte_lexer
// Streaming lexer: one source byte per request, up to three token results.
// The first result of a request is valid in the cycle after accept.
// One request per cycle while no request gives more than one result and no
// result stalls; more results hold the single result port until all are taken.
// Reset clears the lexer state to line 1, column 1 and empties the results.
// ----------------------------------------------------------------------------
module markup_byte_lexer (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  mbl_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output mbl_pkg::rsp_type rsp_data
);

   mbl_pkg::lex_mode_type mode_ff, mode_in, mode_mid;
   logic                  star_ff, star_in;
   mbl_pkg::pos_type      line_ff, line_in;
   mbl_pkg::pos_type      col_ff, col_in;
   mbl_pkg::pos_type      slash_line_ff, slash_line_in;
   mbl_pkg::pos_type      slash_col_ff, slash_col_in;
   mbl_pkg::pos_type      tok_line_ff, tok_line_in;
   mbl_pkg::pos_type      tok_col_ff, tok_col_in;

   mbl_pkg::rsp_type      rsp_slot_ff [3];
   mbl_pkg::rsp_type      rsp_slot_in [3];
   logic [1:0]            rsp_cnt_ff, rsp_cnt_in;
   logic [1:0]            rsp_idx_ff;

   logic                  req_accept, rsp_accept;
   logic [7:0]            b;
   logic                  has, last;
   logic                  is_alpha, is_digit, is_space;
   logic                  ident_cont, num_cont;
   logic                  go_normal;
   mbl_pkg::lex_mode_type normal_mode;
   logic [2:0]            normal_kind;

   function automatic mbl_pkg::pos_type sat_inc(input mbl_pkg::pos_type x);
      return (x == mbl_pkg::POS_MAX) ? x : x + mbl_pkg::POS_ONE;
   endfunction

   function automatic mbl_pkg::rsp_type make_rsp(
      input logic [2:0]       kind,
      input logic             begins,
      input logic             has_char,
      input logic [7:0]       ch,
      input mbl_pkg::pos_type ln,
      input mbl_pkg::pos_type co,
      input logic             unterm
   );
      mbl_pkg::rsp_type r;
      r.kind         = kind;
      r.begins       = begins;
      r.has_char     = has_char;
      r.char_value   = has_char ? ch : 8'd0;
      r.start_line   = ln;
      r.start_column = co;
      r.unterminated = unterm;
      r.last         = 1'b0;
      return r;
   endfunction

   // Handshakes. A request is taken if the buffer is empty or drains this cycle.
   assign req_stall  = !((rsp_cnt_ff == 2'd0) || ((rsp_cnt_ff == 2'd1) && !rsp_stall));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (rsp_cnt_ff != 2'd0);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign rsp_data   = rsp_slot_ff[rsp_idx_ff];

   // Byte classification.
   assign b    = req_data.byte_value;
   assign has  = req_data.has_byte;
   assign last = req_data.is_last;

   assign is_alpha   = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   assign is_digit   = (b >= 8'h30) && (b <= 8'h39);
   assign is_space   = (b == mbl_pkg::CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
   assign ident_cont = is_alpha || is_digit || (b == mbl_pkg::CH_UNDERSCORE)
                       || (b == mbl_pkg::CH_DASH);
   assign num_cont   = is_digit || (b == mbl_pkg::CH_DOT);

   // The byte is lexed from scratch when the current mode does not absorb it.
   assign go_normal = has && (
      (mode_ff == mbl_pkg::MODE_NORMAL) ||
      ((mode_ff == mbl_pkg::MODE_SLASH) && (b != mbl_pkg::CH_SLASH)
         && (b != mbl_pkg::CH_STAR)) ||
      ((mode_ff == mbl_pkg::MODE_BLOCKCOM) && !(star_ff && (b == mbl_pkg::CH_SLASH))
         && last) ||
      ((mode_ff == mbl_pkg::MODE_IDENT) && !ident_cont) ||
      ((mode_ff == mbl_pkg::MODE_NUMBER) && !num_cont));

   always_comb begin
      normal_kind = mbl_pkg::KIND_IDENT;
      unique case (b)
         mbl_pkg::CH_LBRACE:    normal_kind = mbl_pkg::KIND_LBRACE;
         mbl_pkg::CH_RBRACE:    normal_kind = mbl_pkg::KIND_RBRACE;
         mbl_pkg::CH_COLON:     normal_kind = mbl_pkg::KIND_COLON;
         mbl_pkg::CH_SEMICOLON: normal_kind = mbl_pkg::KIND_SEMICOLON;
         default: begin
            if (is_digit) begin
               normal_kind = mbl_pkg::KIND_NUMBER;
            end
         end
      endcase
   end

   always_comb begin
      if (b == mbl_pkg::CH_QUOTE) begin
         normal_mode = mbl_pkg::MODE_STRING;
      end else if ((b == mbl_pkg::CH_SLASH) && !last) begin
         normal_mode = mbl_pkg::MODE_SLASH;
      end else if (is_alpha || (b == mbl_pkg::CH_UNDERSCORE)) begin
         normal_mode = mbl_pkg::MODE_IDENT;
      end else if (is_digit) begin
         normal_mode = mbl_pkg::MODE_NUMBER;
      end else begin
         normal_mode = mbl_pkg::MODE_NORMAL;
      end
   end

   // Next state of the lexer mode.
   always_comb begin
      mode_mid = mode_ff;
      star_in  = star_ff;
      if (has) begin
         unique case (mode_ff)
            mbl_pkg::MODE_SLASH: begin
               if (b == mbl_pkg::CH_SLASH) begin
                  mode_mid = mbl_pkg::MODE_LINECOM;
               end else if (b == mbl_pkg::CH_STAR) begin
                  mode_mid = mbl_pkg::MODE_BLOCKCOM;
                  star_in  = 1'b0;
               end
            end
            mbl_pkg::MODE_LINECOM: begin
               if (b == mbl_pkg::CH_NEWLINE) begin
                  mode_mid = mbl_pkg::MODE_NORMAL;
               end
            end
            mbl_pkg::MODE_BLOCKCOM: begin
               if (star_ff && (b == mbl_pkg::CH_SLASH)) begin
                  star_in  = 1'b0;
                  mode_mid = mbl_pkg::MODE_NORMAL;
               end else if (last) begin
                  star_in = 1'b0;
               end else begin
                  star_in = (b == mbl_pkg::CH_STAR);
               end
            end
            mbl_pkg::MODE_STRING: begin
               if (b == mbl_pkg::CH_QUOTE) begin
                  mode_mid = mbl_pkg::MODE_NORMAL;
               end else if ((b == mbl_pkg::CH_BACKSLASH) && !last) begin
                  mode_mid = mbl_pkg::MODE_ESCAPE;
               end
            end
            mbl_pkg::MODE_ESCAPE: mode_mid = mbl_pkg::MODE_STRING;
            default: ;
         endcase
         if (go_normal) begin
            mode_mid = normal_mode;
         end
      end
      mode_in = mode_mid;
      if (last) begin
         mode_in = mbl_pkg::MODE_NORMAL;
         star_in = 1'b0;
      end
   end

   // Positions and the results of one request.
   always_comb begin
      logic [1:0] n;
      logic [7:0] esc;
      logic       unterm;
      n             = 2'd0;
      esc           = b;
      unterm        = 1'b0;
      line_in       = line_ff;
      col_in        = col_ff;
      slash_line_in = slash_line_ff;
      slash_col_in  = slash_col_ff;
      tok_line_in   = tok_line_ff;
      tok_col_in    = tok_col_ff;
      for (int i = 0; i < 3; i++) begin
         rsp_slot_in[i] = '0;
      end

      if (has) begin
         unique case (mode_ff)
            mbl_pkg::MODE_SLASH: begin
               if ((b == mbl_pkg::CH_SLASH) || (b == mbl_pkg::CH_STAR)) begin
                  col_in = sat_inc(col_in);
               end else begin
                  rsp_slot_in[n] = make_rsp(mbl_pkg::KIND_IDENT, 1'b1, 1'b1,
                     mbl_pkg::CH_SLASH, slash_line_ff, slash_col_ff, 1'b0);
                  n = n + 2'd1;
               end
            end
            mbl_pkg::MODE_LINECOM: begin
               if (b == mbl_pkg::CH_NEWLINE) begin
                  line_in = sat_inc(line_in);
                  col_in  = mbl_pkg::POS_ONE;
               end else begin
                  col_in = sat_inc(col_in);
               end
            end
            mbl_pkg::MODE_BLOCKCOM: begin
               if (star_ff && (b == mbl_pkg::CH_SLASH)) begin
                  col_in = sat_inc(col_in);
               end else if (!last) begin
                  if (b == mbl_pkg::CH_NEWLINE) begin
                     line_in = sat_inc(line_in);
                     col_in  = mbl_pkg::POS_ONE;
                  end else begin
                     col_in = sat_inc(col_in);
                  end
               end
            end
            mbl_pkg::MODE_STRING: begin
               if ((b == mbl_pkg::CH_QUOTE)
                   || ((b == mbl_pkg::CH_BACKSLASH) && !last)) begin
                  col_in = sat_inc(col_in);
               end else begin
                  rsp_slot_in[n] = make_rsp(mbl_pkg::KIND_STRING, 1'b0, 1'b1, b,
                     tok_line_ff, tok_col_ff, 1'b0);
                  n = n + 2'd1;
                  if (b == mbl_pkg::CH_NEWLINE) begin
                     line_in = sat_inc(line_in);
                     col_in  = mbl_pkg::POS_ONE;
                  end else begin
                     col_in = sat_inc(col_in);
                  end
               end
            end
            mbl_pkg::MODE_ESCAPE: begin
               if (b == mbl_pkg::CH_LOWER_N) begin
                  esc = mbl_pkg::CH_NEWLINE;
               end else if (b == mbl_pkg::CH_LOWER_T) begin
                  esc = mbl_pkg::CH_TAB;
               end else if (b == mbl_pkg::CH_LOWER_R) begin
                  esc = mbl_pkg::CH_RETURN;
               end
               rsp_slot_in[n] = make_rsp(mbl_pkg::KIND_STRING, 1'b0, 1'b1, esc,
                  tok_line_ff, tok_col_ff, 1'b0);
               n = n + 2'd1;
               if (b == mbl_pkg::CH_NEWLINE) begin
                  line_in = sat_inc(line_in);
                  col_in  = mbl_pkg::POS_ONE;
               end else begin
                  col_in = sat_inc(col_in);
               end
            end
            mbl_pkg::MODE_IDENT: begin
               if (ident_cont) begin
                  rsp_slot_in[n] = make_rsp(mbl_pkg::KIND_IDENT, 1'b0, 1'b1, b,
                     tok_line_ff, tok_col_ff, 1'b0);
                  n = n + 2'd1;
                  col_in = sat_inc(col_in);
               end
            end
            mbl_pkg::MODE_NUMBER: begin
               if (num_cont) begin
                  rsp_slot_in[n] = make_rsp(mbl_pkg::KIND_NUMBER, 1'b0, 1'b1, b,
                     tok_line_ff, tok_col_ff, 1'b0);
                  n = n + 2'd1;
                  col_in = sat_inc(col_in);
               end
            end
            default: ;
         endcase

         if (go_normal) begin
            if (is_space) begin
               if (b == mbl_pkg::CH_NEWLINE) begin
                  line_in = sat_inc(line_in);
                  col_in  = mbl_pkg::POS_ONE;
               end else begin
                  col_in = sat_inc(col_in);
               end
            end else if (b == mbl_pkg::CH_QUOTE) begin
               tok_line_in    = line_in;
               tok_col_in     = col_in;
               rsp_slot_in[n] = make_rsp(mbl_pkg::KIND_STRING, 1'b1, 1'b0, 8'd0,
                  line_in, col_in, 1'b0);
               n = n + 2'd1;
               col_in = sat_inc(col_in);
            end else if ((b == mbl_pkg::CH_SLASH) && !last) begin
               slash_line_in = line_in;
               slash_col_in  = col_in;
               col_in        = sat_inc(col_in);
            end else begin
               tok_line_in    = line_in;
               tok_col_in     = col_in;
               rsp_slot_in[n] = make_rsp(normal_kind, 1'b1, 1'b1, b,
                  line_in, col_in, 1'b0);
               n = n + 2'd1;
               col_in = sat_inc(col_in);
            end
         end
      end

      if (last) begin
         // A pending slash or escape is flushed before the end token.
         if (mode_mid == mbl_pkg::MODE_SLASH) begin
            rsp_slot_in[n] = make_rsp(mbl_pkg::KIND_IDENT, 1'b1, 1'b1,
               mbl_pkg::CH_SLASH, slash_line_in, slash_col_in, 1'b0);
            n = n + 2'd1;
         end else if (mode_mid == mbl_pkg::MODE_ESCAPE) begin
            rsp_slot_in[n] = make_rsp(mbl_pkg::KIND_STRING, 1'b0, 1'b1,
               mbl_pkg::CH_BACKSLASH, tok_line_in, tok_col_in, 1'b0);
            n = n + 2'd1;
         end
         unterm = (mode_mid == mbl_pkg::MODE_STRING) || (mode_mid == mbl_pkg::MODE_ESCAPE);
         rsp_slot_in[n] = make_rsp(mbl_pkg::KIND_END, 1'b1, 1'b0, 8'd0,
            line_in, col_in, unterm);
         n = n + 2'd1;
         line_in       = mbl_pkg::POS_ONE;
         col_in        = mbl_pkg::POS_ONE;
         slash_line_in = mbl_pkg::POS_ONE;
         slash_col_in  = mbl_pkg::POS_ONE;
         tok_line_in   = mbl_pkg::POS_ONE;
         tok_col_in    = mbl_pkg::POS_ONE;
      end

      if (n != 2'd0) begin
         rsp_slot_in[n - 2'd1].last = 1'b1;
      end
      rsp_cnt_in = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= mbl_pkg::MODE_NORMAL;
         star_ff       <= 1'b0;
         line_ff       <= mbl_pkg::POS_ONE;
         col_ff        <= mbl_pkg::POS_ONE;
         slash_line_ff <= mbl_pkg::POS_ONE;
         slash_col_ff  <= mbl_pkg::POS_ONE;
         tok_line_ff   <= mbl_pkg::POS_ONE;
         tok_col_ff    <= mbl_pkg::POS_ONE;
         rsp_cnt_ff    <= 2'd0;
         rsp_idx_ff    <= 2'd0;
      end else if (req_accept) begin
         mode_ff       <= mode_in;
         star_ff       <= star_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
         slash_line_ff <= slash_line_in;
         slash_col_ff  <= slash_col_in;
         tok_line_ff   <= tok_line_in;
         tok_col_ff    <= tok_col_in;
         rsp_cnt_ff    <= rsp_cnt_in;
         rsp_idx_ff    <= 2'd0;
      end else if (rsp_accept) begin
         rsp_cnt_ff <= rsp_cnt_ff - 2'd1;
         rsp_idx_ff <= rsp_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int i = 0; i < 3; i++) begin
            rsp_slot_ff[i] <= rsp_slot_in[i];
         end
      end
   end

endmodule

/* sv/mbl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbl_checker
// Port-level checks for the markup byte lexer, bound into each lexer instance.
// ----------------------------------------------------------------------------
module mbl_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mbl_pkg::rsp_type rsp_data
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Reset empties the result buffer.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With no result pending the lexer always takes a request.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while result buffer empty");

   // The end token closes the results of its request, and only it flags strings.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.kind == mbl_pkg::KIND_END) || rsp_data.unterminated)
      |-> rsp_data.last && (rsp_data.kind == mbl_pkg::KIND_END))
      else $error("end token malformed");

   // A result without a character carries a zero character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_char |-> rsp_data.char_value == 8'd0)
      else $error("character present without has_char");

endmodule

bind markup_byte_lexer mbl_checker u_mbl_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the markup byte lexer. Source texts, directed and
// random, are streamed into the lexer under random sender and receiver
// idling. Each accepted request runs through a token predictor, and every
// token result is compared field by field with the oldest predicted token.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_PER_PHASE = 75;
   localparam int PRINT_CAP = 50;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   mbl_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   mbl_pkg::rsp_type rsp_data;

   markup_byte_lexer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   mbl_pkg::req_type pending_requests[$];
   mbl_pkg::req_type text_buf[$];
   mbl_pkg::rsp_type token_queue[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int accepted_count = 0;
   int checked_count = 0;
   int cycle_count = 0;

   // Predictor state.
   mbl_pkg::lex_mode_type scan_mode;
   logic                  star_pending;
   mbl_pkg::pos_type      line_now, column_now;
   mbl_pkg::pos_type      slash_at_line, slash_at_column;
   mbl_pkg::pos_type      token_line, token_column;

   function automatic void clear_scanner();
      scan_mode = mbl_pkg::MODE_NORMAL;
      star_pending = 1'b0;
      line_now = mbl_pkg::POS_ONE;
      column_now = mbl_pkg::POS_ONE;
      slash_at_line = mbl_pkg::POS_ONE;
      slash_at_column = mbl_pkg::POS_ONE;
      token_line = mbl_pkg::POS_ONE;
      token_column = mbl_pkg::POS_ONE;
   endfunction

   function automatic mbl_pkg::pos_type pos_inc(mbl_pkg::pos_type p);
      return (p == mbl_pkg::POS_MAX) ? p : p + mbl_pkg::POS_ONE;
   endfunction

   function automatic bit is_letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_blank(logic [7:0] b);
      return b == mbl_pkg::CH_SPACE || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic void step_position(logic [7:0] b);
      if (b == mbl_pkg::CH_NEWLINE) begin
         line_now = pos_inc(line_now);
         column_now = mbl_pkg::POS_ONE;
      end else begin
         column_now = pos_inc(column_now);
      end
   endfunction

   function automatic void push_token(logic [2:0] kind, logic begins, logic has_char,
                                      logic [7:0] ch, mbl_pkg::pos_type ln,
                                      mbl_pkg::pos_type co, logic unterm);
      mbl_pkg::rsp_type t;
      t.kind = kind;
      t.begins = begins;
      t.has_char = has_char;
      t.char_value = has_char ? ch : 8'h00;
      t.start_line = ln;
      t.start_column = co;
      t.unterminated = unterm;
      t.last = 1'b0;
      token_queue.insert(token_queue.size(), t);
   endfunction

   function automatic void open_token(logic [2:0] kind, logic [7:0] b);
      token_line = line_now;
      token_column = column_now;
      push_token(kind, 1'b1, 1'b1, b, token_line, token_column, 1'b0);
      column_now = pos_inc(column_now);
   endfunction

   function automatic void lex_fresh(logic [7:0] b, bit fin);
      scan_mode = mbl_pkg::MODE_NORMAL;
      if (is_blank(b)) begin
         step_position(b);
      end else if (b == mbl_pkg::CH_LBRACE) begin
         open_token(mbl_pkg::KIND_LBRACE, b);
      end else if (b == mbl_pkg::CH_RBRACE) begin
         open_token(mbl_pkg::KIND_RBRACE, b);
      end else if (b == mbl_pkg::CH_COLON) begin
         open_token(mbl_pkg::KIND_COLON, b);
      end else if (b == mbl_pkg::CH_SEMICOLON) begin
         open_token(mbl_pkg::KIND_SEMICOLON, b);
      end else if (b == mbl_pkg::CH_QUOTE) begin
         token_line = line_now;
         token_column = column_now;
         push_token(mbl_pkg::KIND_STRING, 1'b1, 1'b0, 8'h00, token_line, token_column,
                    1'b0);
         column_now = pos_inc(column_now);
         scan_mode = mbl_pkg::MODE_STRING;
      end else if (b == mbl_pkg::CH_SLASH && !fin) begin
         // The slash waits one byte to see whether a comment opens.
         slash_at_line = line_now;
         slash_at_column = column_now;
         column_now = pos_inc(column_now);
         scan_mode = mbl_pkg::MODE_SLASH;
      end else if (is_letter(b) || b == mbl_pkg::CH_UNDERSCORE) begin
         open_token(mbl_pkg::KIND_IDENT, b);
         scan_mode = mbl_pkg::MODE_IDENT;
      end else if (is_digit(b)) begin
         open_token(mbl_pkg::KIND_NUMBER, b);
         scan_mode = mbl_pkg::MODE_NUMBER;
      end else begin
         open_token(mbl_pkg::KIND_IDENT, b);
      end
   endfunction

   function automatic void consume_byte(logic [7:0] b, bit fin);
      logic [7:0] decoded;
      case (scan_mode)
         mbl_pkg::MODE_SLASH: begin
            if (b == mbl_pkg::CH_SLASH) begin
               scan_mode = mbl_pkg::MODE_LINECOM;
               column_now = pos_inc(column_now);
            end else if (b == mbl_pkg::CH_STAR) begin
               scan_mode = mbl_pkg::MODE_BLOCKCOM;
               star_pending = 1'b0;
               column_now = pos_inc(column_now);
            end else begin
               push_token(mbl_pkg::KIND_IDENT, 1'b1, 1'b1, mbl_pkg::CH_SLASH,
                          slash_at_line, slash_at_column, 1'b0);
               lex_fresh(b, fin);
            end
         end
         mbl_pkg::MODE_LINECOM: begin
            if (b == mbl_pkg::CH_NEWLINE) scan_mode = mbl_pkg::MODE_NORMAL;
            step_position(b);
         end
         mbl_pkg::MODE_BLOCKCOM: begin
            if (star_pending && b == mbl_pkg::CH_SLASH) begin
               star_pending = 1'b0;
               scan_mode = mbl_pkg::MODE_NORMAL;
               column_now = pos_inc(column_now);
            end else if (fin) begin
               // A text that ends inside a block comment lexes its final byte.
               star_pending = 1'b0;
               lex_fresh(b, fin);
            end else begin
               star_pending = (b == mbl_pkg::CH_STAR);
               step_position(b);
            end
         end
         mbl_pkg::MODE_STRING: begin
            if (b == mbl_pkg::CH_QUOTE) begin
               scan_mode = mbl_pkg::MODE_NORMAL;
               column_now = pos_inc(column_now);
            end else if (b == mbl_pkg::CH_BACKSLASH && !fin) begin
               scan_mode = mbl_pkg::MODE_ESCAPE;
               column_now = pos_inc(column_now);
            end else begin
               push_token(mbl_pkg::KIND_STRING, 1'b0, 1'b1, b, token_line, token_column,
                          1'b0);
               step_position(b);
            end
         end
         mbl_pkg::MODE_ESCAPE: begin
            decoded = (b == mbl_pkg::CH_LOWER_N) ? mbl_pkg::CH_NEWLINE :
                      (b == mbl_pkg::CH_LOWER_T) ? mbl_pkg::CH_TAB :
                      (b == mbl_pkg::CH_LOWER_R) ? mbl_pkg::CH_RETURN : b;
            push_token(mbl_pkg::KIND_STRING, 1'b0, 1'b1, decoded, token_line,
                       token_column, 1'b0);
            step_position(b);
            scan_mode = mbl_pkg::MODE_STRING;
         end
         mbl_pkg::MODE_IDENT: begin
            if (is_letter(b) || is_digit(b) || b == mbl_pkg::CH_UNDERSCORE
                || b == mbl_pkg::CH_DASH) begin
               push_token(mbl_pkg::KIND_IDENT, 1'b0, 1'b1, b, token_line, token_column,
                          1'b0);
               column_now = pos_inc(column_now);
            end else begin
               lex_fresh(b, fin);
            end
         end
         mbl_pkg::MODE_NUMBER: begin
            if (is_digit(b) || b == mbl_pkg::CH_DOT) begin
               push_token(mbl_pkg::KIND_NUMBER, 1'b0, 1'b1, b, token_line, token_column,
                          1'b0);
               column_now = pos_inc(column_now);
            end else begin
               lex_fresh(b, fin);
            end
         end
         default: lex_fresh(b, fin);
      endcase
   endfunction

   function automatic void predict_tokens(mbl_pkg::req_type r);
      int               first_new;
      logic             unterm;
      mbl_pkg::rsp_type t;
      first_new = token_queue.size();
      if (r.has_byte) consume_byte(r.byte_value, r.is_last);
      if (r.is_last) begin
         if (scan_mode == mbl_pkg::MODE_SLASH) begin
            push_token(mbl_pkg::KIND_IDENT, 1'b1, 1'b1, mbl_pkg::CH_SLASH, slash_at_line,
                       slash_at_column, 1'b0);
         end else if (scan_mode == mbl_pkg::MODE_ESCAPE) begin
            push_token(mbl_pkg::KIND_STRING, 1'b0, 1'b1, mbl_pkg::CH_BACKSLASH,
                       token_line, token_column, 1'b0);
         end
         unterm = (scan_mode == mbl_pkg::MODE_STRING || scan_mode == mbl_pkg::MODE_ESCAPE);
         push_token(mbl_pkg::KIND_END, 1'b1, 1'b0, 8'h00, line_now, column_now, unterm);
         clear_scanner();
      end
      if (token_queue.size() > first_new) begin
         t = token_queue.pop_back();
         t.last = 1'b1;
         token_queue.insert(token_queue.size(), t);
      end
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("mismatch at result %0d: %s is %0h, expected %0h",
                  checked_count, what, got, want);
   endtask

   task automatic check_token(input mbl_pkg::rsp_type got);
      mbl_pkg::rsp_type want;
      if (token_queue.size() == 0) begin
         report_mismatch("unexpected result, kind", got.kind, 0);
      end else begin
         want = token_queue.pop_front();
         if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
         if (got.begins != want.begins) report_mismatch("begins", got.begins, want.begins);
         if (got.has_char != want.has_char)
            report_mismatch("has_char", got.has_char, want.has_char);
         if (got.char_value != want.char_value)
            report_mismatch("char_value", got.char_value, want.char_value);
         if (got.start_line != want.start_line)
            report_mismatch("start_line", got.start_line, want.start_line);
         if (got.start_column != want.start_column)
            report_mismatch("start_column", got.start_column, want.start_column);
         if (got.unterminated != want.unterminated)
            report_mismatch("unterminated", got.unterminated, want.unterminated);
         if (got.last != want.last) report_mismatch("last", got.last, want.last);
      end
      checked_count++;
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_tokens(req_data);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_token(rsp_data);
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, token_queue.size());
         $display("testbench failed");
         $finish;
      end
   end

   // Stimulus construction.
   task automatic add_byte(input logic [7:0] b);
      mbl_pkg::req_type r;
      r.byte_value = b;
      r.has_byte = 1'b1;
      r.is_last = 1'b0;
      text_buf.insert(text_buf.size(), r);
   endtask

   task automatic add_chars(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic add_gap(input bit fin);
      mbl_pkg::req_type r;
      r.byte_value = 8'($urandom_range(255));
      r.has_byte = 1'b0;
      r.is_last = fin;
      text_buf.insert(text_buf.size(), r);
   endtask

   // Closes the text either on its final byte or with a separate empty request.
   task automatic flush_text(input bit bare_end);
      mbl_pkg::req_type r;
      if (bare_end || text_buf.size() == 0) begin
         add_gap(1'b1);
      end else begin
         r = text_buf.pop_back();
         r.is_last = 1'b1;
         text_buf.insert(text_buf.size(), r);
      end
      while (text_buf.size() > 0)
         pending_requests.insert(pending_requests.size(), text_buf.pop_front());
   endtask

   function automatic logic [7:0] pick_ident_char(bit first);
      int unsigned sel;
      sel = $urandom_range(first ? 2 : 4);
      case (sel)
         0: return 8'("a" + $urandom_range(25));
         1: return 8'("A" + $urandom_range(25));
         2: return mbl_pkg::CH_UNDERSCORE;
         3: return 8'("0" + $urandom_range(9));
         default: return mbl_pkg::CH_DASH;
      endcase
   endfunction

   function automatic logic [7:0] pick_printable();
      return 8'($urandom_range(8'h7E, 8'h20));
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(5))
         0: return mbl_pkg::CH_SPACE;
         1: return mbl_pkg::CH_TAB;
         2: return mbl_pkg::CH_NEWLINE;
         3: return mbl_pkg::CH_RETURN;
         4: return 8'd11;
         default: return 8'd12;
      endcase
   endfunction

   task automatic add_fragment();
      logic [7:0] b;
      case ($urandom_range(12))
         0, 11: begin
            add_byte(pick_ident_char(1'b1));
            repeat ($urandom_range(4)) add_byte(pick_ident_char(1'b0));
         end
         1: begin
            add_byte(8'("0" + $urandom_range(9)));
            repeat ($urandom_range(3))
               add_byte(($urandom_range(3) == 0) ? mbl_pkg::CH_DOT
                                                 : 8'("0" + $urandom_range(9)));
         end
         2, 12: begin
            case ($urandom_range(3))
               0: add_byte(mbl_pkg::CH_LBRACE);
               1: add_byte(mbl_pkg::CH_RBRACE);
               2: add_byte(mbl_pkg::CH_COLON);
               default: add_byte(mbl_pkg::CH_SEMICOLON);
            endcase
         end
         3, 4: repeat ($urandom_range(1, 2)) add_byte(pick_blank());
         5: begin
            add_byte(mbl_pkg::CH_QUOTE);
            repeat ($urandom_range(4)) begin
               if ($urandom_range(3) == 0) begin
                  add_byte(mbl_pkg::CH_BACKSLASH);
                  case ($urandom_range(5))
                     0: add_byte(mbl_pkg::CH_LOWER_N);
                     1: add_byte(mbl_pkg::CH_LOWER_T);
                     2: add_byte(mbl_pkg::CH_LOWER_R);
                     3: add_byte(mbl_pkg::CH_QUOTE);
                     4: add_byte(mbl_pkg::CH_BACKSLASH);
                     default: add_byte(pick_printable());
                  endcase
               end else if ($urandom_range(5) == 0) begin
                  add_byte(8'($urandom_range(255)));
               end else begin
                  add_byte(pick_printable());
               end
            end
            // Now and then the string stays open.
            if ($urandom_range(9) != 0) add_byte(mbl_pkg::CH_QUOTE);
         end
         6: begin
            add_chars("//");
            repeat ($urandom_range(5)) add_byte(pick_printable());
            add_byte(mbl_pkg::CH_NEWLINE);
         end
         7: begin
            add_chars("/*");
            repeat ($urandom_range(5)) begin
               case ($urandom_range(4))
                  0: b = mbl_pkg::CH_STAR;
                  1: b = mbl_pkg::CH_SLASH;
                  2: b = mbl_pkg::CH_NEWLINE;
                  default: b = pick_printable();
               endcase
               add_byte(b);
            end
            if ($urandom_range(9) != 0) add_chars("*/");
         end
         8: add_byte(mbl_pkg::CH_SLASH);
         9: add_byte(8'($urandom_range(255)));
         default: add_gap(1'b0);
      endcase
   endtask

   task automatic add_random_texts(input int target);
      int goal;
      goal = pending_requests.size() + target;
      while (pending_requests.size() < goal) begin
         repeat ($urandom_range(1, 8)) add_fragment();
         flush_text($urandom_range(4) == 0);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || token_queue.size() != 0);
   endtask

   initial begin
      clear_scanner();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sender idles rarely, receiver stalls often.
      send_idle_pct = 11;
      recv_idle_pct = 52;
      add_chars("{a-1:2.;}");
      flush_text(1'b0);
      // Open string with an escape left pending, closed by an empty request.
      add_chars("\"\\n\\");
      flush_text(1'b1);
      // Slash followed by a normal byte, then a slash as the final byte.
      add_chars("/x/");
      flush_text(1'b0);
      // Unterminated block comment: its final byte is lexed again.
      add_chars("/*");
      add_byte(8'hC8);
      flush_text(1'b0);
      // Backslash as the final byte of a string.
      add_chars("\"\\");
      flush_text(1'b0);
      // Pending slash, an empty request that is not last, then a bare end.
      add_byte(mbl_pkg::CH_SLASH);
      add_gap(1'b0);
      flush_text(1'b1);
      add_random_texts(RANDOM_PER_PHASE);
      wait_drained();

      send_idle_pct = 52;
      recv_idle_pct = 11;
      add_random_texts(RANDOM_PER_PHASE);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_texts(RANDOM_PER_PHASE);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (token_queue.size() != 0)
         report_mismatch("results never delivered", token_queue.size(), 0);
      $display("%0d requests accepted, %0d token results checked, %0d mismatches",
               accepted_count, checked_count, error_count);
      $display("covered directed corner texts and random markup under three idle mixes");
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
